/* rtl/core/wmsd_pkg.sv */
package wmsd_pkg;

  localparam int unsigned WINDOW    = 5;
  localparam int unsigned REPEATS   = 5;
  localparam int unsigned NREADINGS = 5;
  localparam int unsigned QDEPTH    = 2;

  localparam int unsigned IDX_W  = $clog2(NREADINGS);
  localparam int unsigned REP_W  = $clog2(REPEATS + 1);
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // floor(x / 100) == (x * DIV100_MAGIC) >> DIV100_SHIFT for every 32-bit x
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
  localparam int unsigned DIV100_SHIFT = 37;
  localparam logic [16:0] ROUND_HALF   = 17'd50;
  localparam logic [15:0] CAL_RESET    = 16'd100;

  typedef enum logic [2:0] {
    ACT_SAMPLE  = 3'd0,
    ACT_REPORT  = 3'd1,
    ACT_CAPTURE = 3'd2,
    ACT_INIT    = 3'd3,
    ACT_RESTORE = 3'd4
  } action_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TOTAL  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] msg_counter;
    logic [15:0] reading_age0;
    logic [15:0] reading_age1;
    logic [15:0] reading_age2;
    logic [15:0] reading_age3;
    logic [15:0] reading_age4;
    logic        active;
  } wmsd_in_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] amount;
    logic [9:0]  amount_hundreds;
    logic        last;
  } wmsd_out_t;

  typedef struct packed {
    logic                       kind;
    logic [NREADINGS-1:0]       used;
    logic [NREADINGS-1:0][15:0] off;
  } wmsd_job_t;

  // Wrap formula: below start the offset comes out one short of the modular difference.
  function automatic logic [15:0] wrap_offset(logic [15:0] rd, logic [15:0] start);
    logic [15:0] diff;
    diff = rd - start;
    return diff - {15'd0, (rd < start)};
  endfunction

endpackage

/* rtl/core/wmsd_front.sv */
module wmsd_front
  import wmsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  wmsd_in_t  in_data_i,
  input  logic      q_full_i,
  output logic      push_o,
  output wmsd_job_t job_o
);

  logic [15:0] last_counter_q, last_counter_d;
  logic [15:0] last_reading_q, last_reading_d;
  logic [15:0] start_q, start_d;
  logic [15:0] restart_q, restart_d;

  logic                       accept;
  logic [NREADINGS-1:0][15:0] rd;
  logic [NREADINGS-1:0]       used;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign rd[0] = in_data_i.reading_age0;
  assign rd[1] = in_data_i.reading_age1;
  assign rd[2] = in_data_i.reading_age2;
  assign rd[3] = in_data_i.reading_age3;
  assign rd[4] = in_data_i.reading_age4;

  // Serial-number compare of each reading's counter against the stored one.
  always_comb begin
    logic [15:0] cnt;
    logic [15:0] diff;
    for (int i = 0; i < NREADINGS; i++) begin
      cnt     = in_data_i.msg_counter - 16'(i);
      diff    = cnt - last_counter_q;
      used[i] = (i < WINDOW) && in_data_i.active && (diff != 16'd0) && !diff[15];
    end
  end

  always_comb begin
    last_counter_d = last_counter_q;
    last_reading_d = last_reading_q;
    start_d        = start_q;
    restart_d      = restart_q;
    push_o         = 1'b0;
    job_o.kind     = KIND_SAMPLE;
    job_o.used     = used;
    for (int i = 0; i < NREADINGS; i++) begin
      job_o.off[i] = wrap_offset(rd[i], start_q);
    end
    if (accept) begin
      unique case (in_data_i.action)
        ACT_SAMPLE: begin
          push_o         = |used;
          last_reading_d = rd[0];
          last_counter_d = in_data_i.msg_counter;
        end
        ACT_REPORT: begin
          push_o       = in_data_i.active;
          job_o.kind   = KIND_TOTAL;
          job_o.used   = NREADINGS'(1);
          job_o.off[0] = wrap_offset(last_reading_q, start_q);
        end
        ACT_CAPTURE: start_d = last_reading_q;
        ACT_INIT: begin
          restart_d      = start_q;
          last_counter_d = 16'd0;
        end
        ACT_RESTORE: start_d = restart_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_counter_q <= '0;
      last_reading_q <= '0;
      start_q        <= '0;
      restart_q      <= '0;
    end else begin
      last_counter_q <= last_counter_d;
      last_reading_q <= last_reading_d;
      start_q        <= start_d;
      restart_q      <= restart_d;
    end
  end

endmodule

/* rtl/core/wmsd_queue.sv */
module wmsd_queue
  import wmsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  wmsd_job_t data_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      pop_i,
  output wmsd_job_t data_o
);

  wmsd_job_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
    end
  end

endmodule

/* rtl/core/wmsd_back.sv */
module wmsd_back
  import wmsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] cal_percent_i,
  input  logic        job_valid_i,
  input  wmsd_job_t   job_i,
  output logic        job_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output wmsd_out_t   out_data_o
);

  logic [NREADINGS-1:0] done_q;
  logic [NREADINGS-1:0] pending, rest;
  logic [IDX_W-1:0]     sel_idx;
  logic                 sel_last, issue;

  logic        a_vld_q, a_kind_q, a_last_q;
  logic [31:0] a_prod_q;
  logic        b_vld_q, b_kind_q, b_last_q;
  logic [15:0] b_amt_q;
  logic        c_vld_q, c_kind_q, c_last_q;
  logic [15:0] c_amt_q;
  logic [REP_W-1:0] rep_q;
  logic        out_vld_q;
  wmsd_out_t   out_q;

  logic        out_free, emit, final_rep, c_free, b_free, a_free;
  logic [63:0] quot_prod;
  logic [16:0] rounded;
  logic [48:0] hund_prod;

  assign pending = job_i.used & ~done_q;

  // Oldest reading first: the highest pending age wins.
  always_comb begin
    sel_idx = '0;
    for (int i = 0; i < NREADINGS; i++) begin
      if (pending[i]) sel_idx = IDX_W'(i);
    end
  end

  assign rest     = pending & ~(NREADINGS'(1) << sel_idx);
  assign sel_last = (rest == '0);

  assign out_free  = !out_vld_q || !out_stall_i;
  assign emit      = c_vld_q && out_free;
  assign final_rep = (c_kind_q == KIND_TOTAL) || (rep_q == REP_W'(REPEATS - 1));
  assign c_free    = !c_vld_q || (out_free && final_rep);
  assign b_free    = !b_vld_q || c_free;
  assign a_free    = !a_vld_q || b_free;
  assign issue     = job_valid_i && a_free;
  assign job_pop_o = issue && sel_last;

  assign quot_prod = 64'(a_prod_q) * 64'(DIV100_MAGIC);
  assign rounded   = {1'b0, c_amt_q} + ROUND_HALF;
  assign hund_prod = 49'(rounded) * 49'(DIV100_MAGIC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= '0;
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      rep_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (issue) begin
        done_q <= sel_last ? '0 : (done_q | (NREADINGS'(1) << sel_idx));
      end
      if (a_free) a_vld_q <= issue;
      if (b_free) b_vld_q <= a_vld_q;
      if (c_free) begin
        c_vld_q <= b_vld_q;
        rep_q   <= '0;
      end else if (emit) begin
        rep_q <= rep_q + 1'b1;
      end
      if (out_free) out_vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      a_prod_q <= 32'(cal_percent_i) * 32'(job_i.off[sel_idx]);
      a_kind_q <= job_i.kind;
      a_last_q <= sel_last;
    end
    if (a_vld_q && b_free) begin
      b_amt_q  <= quot_prod[DIV100_SHIFT +: 16];
      b_kind_q <= a_kind_q;
      b_last_q <= a_last_q;
    end
    if (b_vld_q && c_free) begin
      c_amt_q  <= b_amt_q;
      c_kind_q <= b_kind_q;
      c_last_q <= b_last_q;
    end
    if (emit) begin
      out_q.kind            <= c_kind_q;
      out_q.amount          <= c_amt_q;
      out_q.amount_hundreds <= (c_kind_q == KIND_TOTAL) ? hund_prod[DIV100_SHIFT +: 10]
                                                        : 10'd0;
      out_q.last            <= c_last_q && final_rep;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_total_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.kind == KIND_TOTAL) |-> out_q.last)
    else $error("total beat without last");
  a_sample_hund: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.kind == KIND_SAMPLE) |-> (out_q.amount_hundreds == 10'd0))
    else $error("sample beat carries hundreds");
  a_rep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q |-> (rep_q < REP_W'(REPEATS)))
    else $error("repeat count overrun");
  a_job_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> (pending != '0))
    else $error("queued job with no pending reading");
`endif

endmodule

/* rtl/core/windowed_meter_sample_dedup_scale_unit.sv */
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   in_data_i  (wmsd_in_t)
// out      output     out_valid_o / out_stall_i out_data_o (wmsd_out_t)
// cfg      input      cfg_we_i                  cfg_wdata_i (cal_percent)
//
// An item is taken in the cycle it shows whenever the two-entry job queue has room.
// A sample with n fresh readings gives 5n beats, back to back unless the output stalls;
// a total report gives one beat. The back end runs a multiply stage, a divide-by-100
// stage, a repeat stage and an output register.
// Reset clears control state, not payload regs; sets cal_percent to 100; no clearing pass.
// Output stall holds the back end only; the front keeps taking items until the queue fills.
module windowed_meter_sample_dedup_scale_unit
  import wmsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  wmsd_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output wmsd_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] cal_percent_q;
  logic        push, q_full, q_valid, q_pop;
  wmsd_job_t   push_job, head_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_percent_q <= CAL_RESET;
    end else if (cfg_we_i) begin
      cal_percent_q <= cfg_wdata_i;
    end
  end

  wmsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  wmsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (head_job)
  );

  wmsd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cal_percent_i (cal_percent_q),
    .job_valid_i   (q_valid),
    .job_i         (head_job),
    .job_pop_o     (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

/* tb/sv/testbench.sv */
module testbench;
  import wmsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEMS_PER_PHASE = 67;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned IN_BITS         = $bits(wmsd_in_t);

  localparam logic [2:0] ACT_RSVD5 = 3'd5;
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_LIGHT,
    HOLD_HEAVY,
    HOLD_EVERY_THIRD
  } hold_mode_e;

  typedef struct {
    wmsd_in_t  msg;
    logic      pinned;
    wmsd_out_t want;
  } dir_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  wmsd_in_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  wmsd_out_t   out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  // predictor state
  logic [15:0] cal_pct;
  logic [15:0] prev_ctr;
  logic [15:0] prev_rd;
  logic [15:0] start_rd;
  logic [15:0] saved_start;

  wmsd_out_t   due_beats[$];
  dir_row_t    dir_tab[$];
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left   = 0;

  // stimulus generator: a meter whose counter and readings move forward
  logic [15:0] gen_ctr;
  logic [15:0] gen_hist [NREADINGS];

  windowed_meter_sample_dedup_scale_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [15:0] scale_reading(logic [15:0] rd);
    logic [15:0] off;
    logic [31:0] prod;
    if (rd >= start_rd) begin
      off = rd - start_rd;
    end else begin
      // one short of the modular difference, on purpose
      off = (16'hffff - start_rd) + rd;
    end
    prod = 32'(cal_pct) * 32'(off);
    return 16'(prod / 32'd100);
  endfunction

  task automatic compute_meter_results(input wmsd_in_t msg, input logic pinned,
                                       input wmsd_out_t want);
    wmsd_out_t   beats[$];
    wmsd_out_t   b;
    logic [15:0] rd [NREADINGS];
    logic [15:0] c;
    logic [15:0] d;
    logic [15:0] amt;
    rd[0] = msg.reading_age0;
    rd[1] = msg.reading_age1;
    rd[2] = msg.reading_age2;
    rd[3] = msg.reading_age3;
    rd[4] = msg.reading_age4;
    case (msg.action)
      ACT_SAMPLE: begin
        if (msg.active) begin
          // oldest first; keep only counters newer than the last one seen
          for (int i = WINDOW - 1; i >= 0; i--) begin
            if (i >= NREADINGS) continue;
            c = msg.msg_counter - 16'(i);
            d = c - prev_ctr;
            if (d == 16'd0 || d[15]) continue;
            amt = scale_reading(rd[i]);
            b.kind            = KIND_SAMPLE;
            b.amount          = amt;
            b.amount_hundreds = '0;
            b.last            = 1'b0;
            repeat (REPEATS) beats.push_back(b);
          end
          if (beats.size() > 0) beats[$].last = 1'b1;
        end
        prev_rd  = rd[0];
        prev_ctr = msg.msg_counter;
      end
      ACT_REPORT: begin
        if (msg.active) begin
          amt = scale_reading(prev_rd);
          b.kind            = KIND_TOTAL;
          b.amount          = amt;
          b.amount_hundreds = 10'((17'(amt) + 17'd50) / 17'd100);
          b.last            = 1'b1;
          beats.push_back(b);
        end
      end
      ACT_CAPTURE: start_rd = prev_rd;
      ACT_INIT: begin
        saved_start = start_rd;
        prev_ctr    = '0;
      end
      ACT_RESTORE: start_rd = saved_start;
      default: ;
    endcase
    if (pinned) begin
      due_beats.push_back(want);
    end else begin
      foreach (beats[k]) due_beats.push_back(beats[k]);
    end
  endtask

  task automatic push_item(input wmsd_in_t msg, input logic pinned, input wmsd_out_t want);
    if (burst_left == 0) begin
      if (in_valid_i) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= msg;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    compute_meter_results(msg, pinned, want);
  endtask

  task automatic write_cal(input logic [15:0] value);
    while (due_beats.size() != 0) @(posedge clk_i);
    // let result-free jobs drain out of the pipe
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cal_pct   = value;
  endtask

  task automatic add_row(input logic [2:0] act, input logic [15:0] ctr,
                         input logic [15:0] a0, input logic [15:0] a1,
                         input logic [15:0] a2, input logic [15:0] a3,
                         input logic [15:0] a4, input logic on,
                         input logic pinned, input logic [15:0] want_amt,
                         input logic [9:0] want_hund);
    dir_row_t r;
    r.msg.action       = act;
    r.msg.msg_counter  = ctr;
    r.msg.reading_age0 = a0;
    r.msg.reading_age1 = a1;
    r.msg.reading_age2 = a2;
    r.msg.reading_age3 = a3;
    r.msg.reading_age4 = a4;
    r.msg.active       = on;
    r.pinned           = pinned;
    r.want.kind            = KIND_TOTAL;
    r.want.amount          = want_amt;
    r.want.amount_hundreds = want_hund;
    r.want.last            = 1'b1;
    dir_tab.push_back(r);
  endtask

  function automatic wmsd_in_t next_meter_msg();
    wmsd_in_t                     msg;
    logic [IN_BITS-1:0]           raw;
    int unsigned                  pick;
    int unsigned                  steps;
    int unsigned                  s;
    raw  = IN_BITS'({$urandom(), $urandom(), $urandom(), $urandom()});
    msg  = raw;
    msg.active = ($urandom_range(0, 7) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      s = $urandom_range(0, 9);
      steps = (s < 6) ? 1 : (s < 8) ? $urandom_range(2, 4) : (s == 8) ? 0
                                                            : $urandom_range(5, 12);
      repeat (steps) begin
        for (int k = NREADINGS - 1; k > 0; k--) gen_hist[k] = gen_hist[k-1];
        gen_hist[0] = gen_hist[0] + 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                                  : $urandom_range(0, 400));
        gen_ctr++;
      end
      msg.action       = ACT_SAMPLE;
      msg.msg_counter  = gen_ctr;
      msg.reading_age0 = gen_hist[0];
      msg.reading_age1 = gen_hist[1];
      msg.reading_age2 = gen_hist[2];
      msg.reading_age3 = gen_hist[3];
      msg.reading_age4 = gen_hist[4];
    end else if (pick < 76) begin
      msg.action = ACT_REPORT;
    end else if (pick < 82) begin
      msg.action = ACT_CAPTURE;
    end else if (pick < 86) begin
      msg.action = ACT_INIT;
    end else if (pick < 90) begin
      msg.action = ACT_RESTORE;
    end else if (pick < 92) begin
      msg.action = ($urandom_range(0, 2) == 0) ? ACT_RSVD5 :
                   ($urandom_range(0, 1) == 0) ? ACT_RSVD6 : ACT_RSVD7;
    end else begin
      // broken sequence: random counter and readings, the counter sometimes followed from here on
      msg.action = ACT_SAMPLE;
      if ($urandom_range(0, 1) == 0) gen_ctr = msg.msg_counter;
    end
    return msg;
  endfunction

  initial begin
    logic [15:0] cal_steps [6];
    wmsd_in_t    msg;
    wmsd_out_t   none;
    int unsigned placed;
    none     = '0;
    cal_steps = '{16'hffff, 16'd0, 16'd1, 16'($urandom), 16'd250, 16'($urandom)};
    cal_pct     = CAL_RESET;
    prev_ctr    = '0;
    prev_rd     = '0;
    start_rd    = '0;
    saved_start = '0;
    gen_ctr     = 16'($urandom);
    foreach (gen_hist[k]) gen_hist[k] = 16'($urandom);

    add_row(ACT_REPORT,  16'd0,     '0, '0, '0, '0, '0, 1'b1, 1'b1, 16'd0, 10'd0);
    add_row(ACT_REPORT,  16'd0,     '0, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0);
    add_row(ACT_SAMPLE,  16'd5,     16'd500, 16'd400, 16'd300, 16'd200, 16'd100,
            1'b1, 1'b0, '0, '0);
    add_row(ACT_REPORT,  16'd0,     '0, '0, '0, '0, '0, 1'b1, 1'b1, 16'd500, 10'd5);
    add_row(ACT_SAMPLE,  16'd5,     16'hffff, 16'd400, 16'd300, 16'd200, 16'd100,
            1'b1, 1'b0, '0, '0);
    add_row(ACT_REPORT,  16'd0,     '0, '0, '0, '0, '0, 1'b1, 1'b1, 16'd65535, 10'd655);
    add_row(ACT_SAMPLE,  16'd7,     16'd700, 16'd600, 16'd500, 16'd400, 16'd300,
            1'b1, 1'b0, '0, '0);
    add_row(ACT_CAPTURE, 16'd0,     '0, '0, '0, '0, '0, 1'b1, 1'b0, '0, '0);
    add_row(ACT_REPORT,  16'd0,     '0, '0, '0, '0, '0, 1'b1, 1'b1, 16'd0, 10'd0);
    add_row(ACT_SAMPLE,  16'd8,     16'd0, 16'd700, 16'd600, 16'd500, 16'd400,
            1'b1, 1'b0, '0, '0);
    add_row(ACT_REPORT,  16'd0,     '0, '0, '0, '0, '0, 1'b1, 1'b1, 16'd64835, 10'd648);
    add_row(ACT_INIT,    16'd0,     '0, '0, '0, '0, '0, 1'b1, 1'b0, '0, '0);
    add_row(ACT_SAMPLE,  16'hffff,  16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
            1'b0, 1'b0, '0, '0);
    add_row(ACT_CAPTURE, 16'd0,     '0, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0);
    add_row(ACT_REPORT,  16'd0,     '0, '0, '0, '0, '0, 1'b1, 1'b1, 16'd0, 10'd0);
    // counter wraps through zero
    add_row(ACT_SAMPLE,  16'd2,     16'h0000, 16'h1234, 16'hfffe, 16'hffff, 16'h8000,
            1'b1, 1'b0, '0, '0);
    add_row(ACT_RESTORE, 16'd0,     '0, '0, '0, '0, '0, 1'b1, 1'b0, '0, '0);
    // newest reading exactly half the counter range ahead: not newer
    add_row(ACT_SAMPLE,  16'h8002,  16'h0001, 16'h02bc, 16'h02bb, 16'h7fff, 16'hfffe,
            1'b1, 1'b0, '0, '0);
    add_row(ACT_REPORT,  16'd0,     '0, '0, '0, '0, '0, 1'b1, 1'b0, '0, '0);
    add_row(ACT_RSVD5,   16'hffff,  16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
            1'b1, 1'b0, '0, '0);
    add_row(ACT_RSVD6,   16'hffff,  16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
            1'b1, 1'b0, '0, '0);
    add_row(ACT_RSVD7,   16'hffff,  16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
            1'b1, 1'b0, '0, '0);
    add_row(ACT_REPORT,  16'd0,     '0, '0, '0, '0, '0, 1'b1, 1'b0, '0, '0);
    add_row(ACT_SAMPLE,  16'h8010,  '0, '0, '0, '0, '0, 1'b1, 1'b0, '0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_cal(CAL_RESET);

    foreach (dir_tab[i]) push_item(dir_tab[i].msg, dir_tab[i].pinned, dir_tab[i].want);
    in_valid_i <= 1'b0;
    burst_left = 0;

    foreach (cal_steps[p]) begin
      write_cal(cal_steps[p]);
      placed = 0;
      while (placed < ITEMS_PER_PHASE) begin
        msg = next_meter_msg();
        push_item(msg, 1'b0, none);
        if (msg.action <= ACT_RESTORE) placed++;
      end
      in_valid_i <= 1'b0;
      burst_left = 0;
    end

    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("windowed_meter_sample_dedup_scale_unit regression: pass");
    end else begin
      $display("windowed_meter_sample_dedup_scale_unit regression: fail");
    end
    $finish;
  end

  // receiver back-pressure: switch between random hold patterns
  initial begin
    hold_mode_e  mode;
    int unsigned span;
    int unsigned tick;
    tick = 0;
    forever begin
      mode = hold_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 80);
      repeat (span) begin
        @(posedge clk_i);
        tick++;
        case (mode)
          HOLD_NONE:        out_stall_i <= 1'b0;
          HOLD_LIGHT:       out_stall_i <= ($urandom_range(0, 3) == 0);
          HOLD_HEAVY:       out_stall_i <= ($urandom_range(0, 9) < 6);
          HOLD_EVERY_THIRD: out_stall_i <= (tick % 3 == 0);
          default:          out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  task automatic note_mismatch(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    wmsd_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_beats.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got kind %0d amt %0d hund %0d last %0d",
                 $realtime, out_data_o.kind, out_data_o.amount,
                 out_data_o.amount_hundreds, out_data_o.last);
        fail_count++;
      end else begin
        want = due_beats.pop_front();
        if (out_data_o.kind !== want.kind)
          note_mismatch("kind", 16'(want.kind), 16'(out_data_o.kind));
        if (out_data_o.amount !== want.amount)
          note_mismatch("amount", want.amount, out_data_o.amount);
        if (out_data_o.amount_hundreds !== want.amount_hundreds)
          note_mismatch("amount_hundreds", 16'(want.amount_hundreds),
                        16'(out_data_o.amount_hundreds));
        if (out_data_o.last !== want.last)
          note_mismatch("last", 16'(want.last), 16'(out_data_o.last));
      end
    end
  end

  // abort when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("windowed_meter_sample_dedup_scale_unit regression: fail");
      $finish;
    end
  end

endmodule

/* files.f */
rtl/core/wmsd_pkg.sv
rtl/core/wmsd_front.sv
rtl/core/wmsd_queue.sv
rtl/core/wmsd_back.sv
rtl/core/windowed_meter_sample_dedup_scale_unit.sv
tb/sv/testbench.sv
